// ===== sv/lgs_pkg.sv =====
// ============================================================================
// lgs_pkg
// Shared types, register indexes and helpers for the linear gradient shader.
// ============================================================================
package lgs_pkg;

    // Defaults for the top-level parameters
    localparam int FRAC_BITS_DEF = 16;
    localparam int MAX_STOPS_DEF = 6;

    // Fixed widths
    localparam int COORD_W  = 13;
    localparam int COEFF_W  = 32;
    localparam int PROD_W   = COEFF_W + COORD_W + 1;   // signed coeff x zero-extended coord
    localparam int T_W      = PROD_W + 2;              // sum of three terms
    localparam int STOP_W   = 3;                       // stop index / stop count
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 64;
    localparam int NUM_PAIRS = 3;

    // Exact divide by 255 for 16-bit operands: (y * 0x8081) >> 23
    localparam logic [15:0] DIV255_MAGIC = 16'h8081;
    localparam int          DIV255_SHIFT = 23;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_CONST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_MODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_PAIR0 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_PAIR1 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_PAIR2 = 3'd7;

    // Tile modes (code 3 behaves as clamp)
    localparam logic [1:0] TILE_CLAMP  = 2'd0;
    localparam logic [1:0] TILE_REPEAT = 2'd1;
    localparam logic [1:0] TILE_MIRROR = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic               row_last;
    } lgs_req_t;

    typedef struct packed {
        logic [31:0] pixel;
        logic        row_last_out;
    } lgs_rsp_t;

    // Pick one ARGB stop word out of the three colour pair registers.
    // Indexes past the last pair fold onto the last pair.
    function automatic logic [31:0] stop_word(
        input logic [CFG_W-1:0]  pair0,
        input logic [CFG_W-1:0]  pair1,
        input logic [CFG_W-1:0]  pair2,
        input logic [STOP_W-1:0] k
    );
        logic [31:0] w;
        case (k)
            3'd0:    w = pair0[31:0];
            3'd1:    w = pair0[63:32];
            3'd2:    w = pair1[31:0];
            3'd3:    w = pair1[63:32];
            3'd4:    w = pair2[31:0];
            3'd5:    w = pair2[63:32];
            default: w = k[0] ? pair2[63:32] : pair2[31:0];
        endcase
        return w;
    endfunction

endpackage

// ===== sv/linear_gradient_pixel_shader_core.sv =====
// Path: an accepted request is registered in stage 0 and its response leaves the stage 7 register.
// Throughput: one pixel per cycle, sustained, while the response side is ready.
// The rate is set by the eight-stage pipeline; each stage stalls only when it
// holds a pixel and the stage after it cannot take it, so bubbles collapse.
// Reset: asynchronous, active low; clears all stage valid bits and loads the
// configuration registers with their reset values. No clearing pass.
// ============================================================================
// linear_gradient_pixel_shader_core
// Linear gradient shader: device pixel in, premultiplied ARGB8888 out.
// ============================================================================
module linear_gradient_pixel_shader_core #(
    parameter int FRAC_BITS = lgs_pkg::FRAC_BITS_DEF,
    parameter int MAX_STOPS = lgs_pkg::MAX_STOPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          req_valid,
    output logic                          req_ready,
    input  lgs_pkg::lgs_req_t             req,
    // response channel
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output lgs_pkg::lgs_rsp_t             rsp,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lgs_pkg::CFG_W-1:0]     cfg_data
);
    import lgs_pkg::*;

    // ------------------------------------------------------------------
    // Derived widths and constants
    // ------------------------------------------------------------------
    localparam int NS    = 8;               // pipeline stages
    localparam int ONE_W = FRAC_BITS + 1;   // folded parameter u in [0, ONE]
    localparam int S_W   = ONE_W + STOP_W;  // u * (n - 1)
    localparam int CH_W  = FRAC_BITS + 8;   // blended channel, up to 255*ONE
    localparam int P_W   = 2 * CH_W;        // channel times alpha

    localparam logic signed [T_W-1:0] T_ONE    = T_W'(1) << FRAC_BITS;
    localparam logic [ONE_W-1:0]      U_ONE    = ONE_W'(1) << FRAC_BITS;
    localparam logic [CH_W-1:0]       HALF_ONE = CH_W'(1) << (FRAC_BITS - 1);
    // Half of 255 * ONE * ONE, the rounding term of the premultiply
    localparam logic [P_W:0]          HALF_D   = (P_W + 1)'(255) << (2 * FRAC_BITS - 1);

    // ------------------------------------------------------------------
    // Configuration registers. The user must write them only while the pipeline
    // is idle (the block does not enforce it), so every stage may read them live.
    // ------------------------------------------------------------------
    logic signed [COEFF_W-1:0] coeff_x_reg;
    logic signed [COEFF_W-1:0] coeff_y_reg;
    logic signed [COEFF_W-1:0] coeff_const_reg;
    logic [1:0]                tile_mode_reg;
    logic [STOP_W-1:0]         stop_count_reg;
    logic [CFG_W-1:0]          color_pair0_reg;
    logic [CFG_W-1:0]          color_pair1_reg;
    logic [CFG_W-1:0]          color_pair2_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_x_reg     <= 32'sd65536;
            coeff_y_reg     <= '0;
            coeff_const_reg <= '0;
            tile_mode_reg   <= TILE_CLAMP;
            stop_count_reg  <= 3'd2;
            color_pair0_reg <= '0;
            color_pair1_reg <= '0;
            color_pair2_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_COEFF_X:     coeff_x_reg     <= cfg_data[COEFF_W-1:0];
                REG_COEFF_Y:     coeff_y_reg     <= cfg_data[COEFF_W-1:0];
                REG_COEFF_CONST: coeff_const_reg <= cfg_data[COEFF_W-1:0];
                REG_TILE_MODE:   tile_mode_reg   <= cfg_data[1:0];
                REG_STOP_COUNT:  stop_count_reg  <= cfg_data[STOP_W-1:0];
                REG_COLOR_PAIR0: color_pair0_reg <= cfg_data;
                REG_COLOR_PAIR1: color_pair1_reg <= cfg_data;
                REG_COLOR_PAIR2: color_pair2_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Effective stop count minus one: zero stops act as one, too many
    // saturate at MAX_STOPS.
    logic [STOP_W-1:0] n_m1;

    always_comb
    begin
        if (stop_count_reg == '0)
            n_m1 = '0;
        else if (stop_count_reg > STOP_W'(MAX_STOPS))
            n_m1 = STOP_W'(MAX_STOPS - 1);
        else
            n_m1 = stop_count_reg - STOP_W'(1);
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. A stage loads when it is empty or when the
    // stage after it loads; the output stage drains on rsp_ready.
    // ------------------------------------------------------------------
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] last_reg;
    logic [NS-1:0] last_next;
    logic [NS-1:0] en;

    always_comb
    begin
        en[NS-1] = !valid_reg[NS-1] || rsp_ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign req_ready = en[0];

    always_comb
    begin
        valid_next[0] = en[0] ? req_valid : valid_reg[0];
        last_next[0]  = req.row_last;
        for (int i = 1; i < NS; i++)
        begin
            valid_next[i] = en[i] ? valid_reg[i-1] : valid_reg[i];
            last_next[i]  = last_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NS; i++)
        begin
            if (en[i])
                last_reg[i] <= last_next[i];
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: the two coordinate products, coefficient times coordinate.
    // Coordinates are unsigned, so they enter the signed multiply with a
    // zero top bit.
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] mx_reg, mx_next;
    logic signed [PROD_W-1:0] my_reg, my_next;

    assign mx_next = coeff_x_reg * $signed({1'b0, req.pixel_x});
    assign my_next = coeff_y_reg * $signed({1'b0, req.pixel_y});

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            mx_reg <= mx_next;
            my_reg <= my_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: t = cx*x + cy*y + c0, exact in T_W bits.
    // ------------------------------------------------------------------
    logic signed [T_W-1:0] t_reg, t_next;

    assign t_next = T_W'(mx_reg) + T_W'(my_reg) + T_W'(coeff_const_reg);

    always_ff @(posedge clk)
    begin
        if (en[1])
            t_reg <= t_next;
    end

    // ------------------------------------------------------------------
    // Stage 2: tile mode folds t into u in [0, ONE].
    //   clamp  - limit to [0, ONE]
    //   repeat - floor fraction
    //   mirror - t mod 2*ONE, reflected above ONE
    // ------------------------------------------------------------------
    logic [ONE_W-1:0] u_reg, u_next;
    logic [ONE_W-1:0] mir;

    assign mir = t_reg[FRAC_BITS:0];

    always_comb
    begin
        case (tile_mode_reg)
            TILE_REPEAT:
                u_next = {1'b0, t_reg[FRAC_BITS-1:0]};
            TILE_MIRROR:
                // 2*ONE - m wraps to the two's complement of m in ONE_W bits
                u_next = (mir > U_ONE) ? (ONE_W'(0) - mir) : mir;
            default:
            begin
                if (t_reg[T_W-1])
                    u_next = '0;
                else if (t_reg > T_ONE)
                    u_next = U_ONE;
                else
                    u_next = t_reg[FRAC_BITS:0];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
            u_reg <= u_next;
    end

    // ------------------------------------------------------------------
    // Stage 3: scale by (n - 1), split into stop index and blend fraction,
    // fetch the two stop words. At the top end the index pins to the last
    // stop with a zero fraction, so nothing past it is read.
    // ------------------------------------------------------------------
    logic [S_W-1:0]       s_val;
    logic [STOP_W:0]      idx_raw;
    logic                 top_end;
    logic [STOP_W-1:0]    idx_lo;
    logic [STOP_W-1:0]    idx_hi;
    logic [FRAC_BITS-1:0] f_reg, f_next;
    logic [31:0]          wlo_reg, wlo_next;
    logic [31:0]          whi_reg, whi_next;

    always_comb
    begin
        s_val   = S_W'(u_reg) * S_W'(n_m1);
        idx_raw = s_val[S_W-1:FRAC_BITS];
        top_end = (idx_raw >= {1'b0, n_m1});
        idx_lo  = top_end ? n_m1 : idx_raw[STOP_W-1:0];
        idx_hi  = top_end ? idx_lo : (idx_lo + STOP_W'(1));
        f_next  = top_end ? '0 : s_val[FRAC_BITS-1:0];
        wlo_next = stop_word(color_pair0_reg, color_pair1_reg, color_pair2_reg, idx_lo);
        whi_next = stop_word(color_pair0_reg, color_pair1_reg, color_pair2_reg, idx_hi);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            f_reg   <= f_next;
            wlo_reg <= wlo_next;
            whi_reg <= whi_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: per-channel blend c_lo*(ONE-f) + c_hi*f, exact.
    // Lane 3 is alpha, lanes 2..0 are R, G, B.
    // ------------------------------------------------------------------
    logic [CH_W-1:0]  blend_reg  [4];
    logic [CH_W-1:0]  blend_next [4];
    logic [ONE_W-1:0] f_inv;

    assign f_inv = U_ONE - {1'b0, f_reg};

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            blend_next[k] = CH_W'((CH_W + 1)'(wlo_reg[8*k +: 8]) * (CH_W + 1)'(f_inv)
                                + (CH_W + 1)'(whi_reg[8*k +: 8]) * (CH_W + 1)'(f_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            for (int k = 0; k < 4; k++)
                blend_reg[k] <= blend_next[k];
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: colour times alpha; alpha itself rounds to 8 bits here.
    // ------------------------------------------------------------------
    logic [P_W-1:0]  prod_reg  [3];
    logic [P_W-1:0]  prod_next [3];
    logic [7:0]      alpha5_reg, alpha5_next;
    logic [CH_W-1:0] alpha_rnd;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            prod_next[k] = P_W'(blend_reg[k]) * P_W'(blend_reg[3]);
        alpha_rnd   = blend_reg[3] + HALF_ONE;
        alpha5_next = alpha_rnd[FRAC_BITS +: 8];
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            for (int k = 0; k < 3; k++)
                prod_reg[k] <= prod_next[k];
            alpha5_reg <= alpha5_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: add the rounding term and drop the 2*FRAC_BITS fraction
    // bits; what is left (below 2^16) still needs dividing by 255.
    // ------------------------------------------------------------------
    logic [15:0]  y_reg  [3];
    logic [15:0]  y_next [3];
    logic [P_W:0] rsum   [3];
    logic [7:0]   alpha6_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            rsum[k]   = (P_W + 1)'(prod_reg[k]) + HALF_D;
            y_next[k] = rsum[k][2*FRAC_BITS +: 16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            for (int k = 0; k < 3; k++)
                y_reg[k] <= y_next[k];
            alpha6_reg <= alpha5_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: divide by 255 through the reciprocal multiply (exact over
    // 16 bits), saturate, pack. This stage is the output register.
    // ------------------------------------------------------------------
    logic [31:0] q     [3];
    logic [7:0]  chan8 [3];
    logic [31:0] pix_reg, pix_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            q[k]     = 32'(y_reg[k]) * 32'(DIV255_MAGIC);
            chan8[k] = (q[k][31:DIV255_SHIFT] > 9'd255) ? 8'hFF : q[k][DIV255_SHIFT +: 8];
        end
        pix_next = {alpha6_reg, chan8[2], chan8[1], chan8[0]};
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
            pix_reg <= pix_next;
    end

    assign rsp_valid         = valid_reg[NS-1];
    assign rsp.pixel         = pix_reg;
    assign rsp.row_last_out  = last_reg[NS-1];

endmodule
